// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 7;

  // Request codes carried in the mode field.
  localparam logic ModeEnq = 1'b0;
  localparam logic ModeDeq = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  // One stored entry.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } spq_entry_t;

  // Request word.
  typedef struct packed {
    logic                    mode;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] priority_req;
  } spq_in_t;

  // Response word.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] out_value;
    logic signed [DataW-1:0] out_priority;
    logic [OccW-1:0]         occupancy;
  } spq_out_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds an entry, compares it against the incoming
// priority and takes the new entry or a neighbor's entry as commanded.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  spq_op_t    op_i,
  input  logic       occ_i,
  input  spq_entry_t new_i,
  input  spq_entry_t left_i,
  input  logic       left_gt_i,
  input  spq_entry_t right_i,
  output spq_entry_t entry_o,
  output logic       gt_o
);

  spq_entry_t entry_q, entry_d;

  // Strictly higher priority than the incoming entry: stay in front of it.
  assign gt_o = occ_i && (entry_q.prio > new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (op_i.enq) begin
      if (gt_o) begin
        entry_d = entry_q;
      end else if (left_gt_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (op_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue built as a row of sorting cells, highest priority in front.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o/in_data_i): mode 0 enqueues the
//   given value and priority, mode 1 dequeues the front entry. Each request
//   word yields exactly one response word on out_valid_o/out_ready_i/
//   out_data_o with a status, the dequeued entry (zero unless a dequeue
//   succeeded) and the occupancy after the request.
//   The response is registered at the edge that accepts the request.
//   One request per cycle while responses drain; every cell updates in
//   the same cycle, so the next request sees the new order at once.
//   Cell j holds the j-th highest entry; ties keep the newest in front. An
//   enqueue shifts every cell behind the insertion point back by one, a
//   dequeue reads cell 0 and shifts the whole row forward by one.
//   Reset clears the occupancy count and the response valid; cell contents
//   stay undefined and only cells below the count are ever looked at.
//   While the response register is full and the receiver stalls, in_ready_o
//   drops and the queue holds.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  spq_out_t        out_q, out_d;

  spq_op_t         op;
  spq_entry_t      new_entry;
  spq_entry_t      cell_entry [DEPTH];
  logic            cell_gt    [DEPTH];
  logic            in_fire;
  logic            is_full, is_empty;
  logic [CntW+OccW-1:0] occ_wide;

  // Accept whenever the response slot is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  assign new_entry.value = in_data_i.value;
  assign new_entry.prio  = in_data_i.priority_req;

  // Broadcast the command; refused requests leave the row alone.
  always_comb begin
    op.enq = in_fire && (in_data_i.mode == ModeEnq) && !is_full;
    op.deq = in_fire && (in_data_i.mode == ModeDeq) && !is_empty;
  end

  always_comb begin
    count_d = count_q;
    if (op.enq) begin
      count_d = count_q + CntW'(1);
    end else if (op.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Occupancy field carries the low bits of the count.
  assign occ_wide = {{OccW{1'b0}}, count_d};

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_fire) begin
      out_valid_d            = 1'b1;
      out_d.status           = ST_OK;
      out_d.out_value        = '0;
      out_d.out_priority     = '0;
      out_d.occupancy        = occ_wide[OccW-1:0];
      if (in_data_i.mode == ModeEnq) begin
        if (is_full) begin
          out_d.status = ST_FULL;
        end
      end else begin
        if (is_empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          // Front cell holds the highest priority, newest among ties.
          out_d.out_value    = cell_entry[0].value;
          out_d.out_priority = cell_entry[0].prio;
        end
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Row of cells; each sees its left and right neighbor.
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    spq_entry_t left_entry, right_entry;
    logic       left_gt;
    logic       occ;

    assign occ = (CntW'(j) < count_q);

    if (j == 0) begin : g_head
      // Nothing stands in front of the head: treat it as outranked.
      assign left_entry = new_entry;
      assign left_gt    = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[j-1];
      assign left_gt    = cell_gt[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[j];
    end else begin : g_inner
      assign right_entry = cell_entry[j+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .occ_i     (occ),
      .new_i     (new_entry),
      .left_i    (left_entry),
      .left_gt_i (left_gt),
      .right_i   (right_entry),
      .entry_o   (cell_entry[j]),
      .gt_o      (cell_gt[j])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input spq_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input spq_out_t out_data_o
);

  localparam logic [OccW-1:0] FullOcc = OccW'(DEPTH);

  // Hold a stalled response word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed");

  // Drop ready while a stalled response occupies the slot.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request accepted over a stalled response");

  // Refused requests carry no entry.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.out_value == '0) && (out_data_o.out_priority == '0))
    else $error("refused response carries data");

  // Full and empty refusals report the matching occupancy.
  a_refused_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      ((out_data_o.status == ST_FULL) && (out_data_o.occupancy == FullOcc)) ||
      ((out_data_o.status == ST_EMPTY) && (out_data_o.occupancy == '0)))
    else $error("refusal status and occupancy disagree");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
